// ===== design/mdre_pkg.sv =====
package mdre_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_W = 2;
	localparam int MAX_BEAT_LOG2 = 6;
	localparam int BYTES_W = 7;

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	localparam logic [11:0] OFF_CONTROL   = 12'h000;
	localparam logic [11:0] OFF_NEXT_CFG  = 12'h004;
	localparam logic [11:0] OFF_NEXT_LEN  = 12'h008;
	localparam logic [11:0] OFF_NEXT_DEST = 12'h010;
	localparam logic [11:0] OFF_NEXT_SRC  = 12'h018;
	localparam logic [11:0] OFF_EXEC_CFG  = 12'h104;
	localparam logic [11:0] OFF_EXEC_LEN  = 12'h108;
	localparam logic [11:0] OFF_EXEC_DEST = 12'h110;
	localparam logic [11:0] OFF_EXEC_SRC  = 12'h118;

	localparam int CTL_CLAIM   = 0;
	localparam int CTL_RUN     = 1;
	localparam int CTL_DONE_IE = 14;
	localparam int CTL_ERR_IE  = 15;
	localparam int CTL_DONE    = 30;
	localparam int CTL_ERR     = 31;
	localparam int CFG_REPEAT  = 2;
	localparam int CFG_WR_POS  = 24;
	localparam int CFG_RD_POS  = 28;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  channel;
		logic [11:0] reg_offset;
		logic [63:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        beat_valid;
		logic [63:0] beat_src;
		logic [63:0] beat_dst;
		logic [6:0]  beat_bytes;
		logic        irq;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic do_step;
	} cmd_t;

	function automatic logic [3:0] size_log2(input logic [31:0] cfg);
		logic [3:0] lg;
		lg = cfg[CFG_WR_POS +: 4];
		if (lg > 4'(MAX_BEAT_LOG2))
			lg = 4'(MAX_BEAT_LOG2);
		return lg;
	endfunction

endpackage

// ===== design/mdre_datapath.sv =====
module mdre_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mdre_pkg::cmd_t      cmd,
	input  mdre_pkg::in_item_t  item,
	output mdre_pkg::out_item_t result
);

	localparam int N = mdre_pkg::CHANNELS;

	logic [31:0] control_q [N];
	logic [31:0] next_cfg_q [N];
	logic [63:0] next_len_q [N];
	logic [63:0] next_dest_q [N];
	logic [63:0] next_src_q [N];
	logic [31:0] exec_cfg_q [N];
	logic [63:0] exec_len_q [N];
	logic [63:0] exec_dest_q [N];
	logic [63:0] exec_src_q [N];
	logic [N-1:0] busy_q;

	logic [mdre_pkg::CH_W-1:0] tsel;
	logic                      tfound;
	logic [63:0]               tsz;
	logic [3:0]                tlg;
	logic                      ch_ok;
	logic [mdre_pkg::CH_W-1:0] c;
	logic [63:0]               rd;
	logic [N-1:0]              irq_nxt;

	assign c = item.channel;
	assign ch_ok = 32'(item.channel) < N;

	// recompute the next control value of one channel (same rules as irq path)
	function automatic logic [31:0] irq_ctl(input logic [mdre_pkg::CH_W-1:0] ch);
		logic [31:0] k;
		logic [31:0] cfg;
		logic [63:0] len;
		logic [63:0] sz;
		k = control_q[ch];
		if (item.action == mdre_pkg::ACT_WRITE) begin
			k = item.write_data[31:0];
			cfg = item.write_data[mdre_pkg::CTL_CLAIM] ? 32'd0 : next_cfg_q[ch];
			len = item.write_data[mdre_pkg::CTL_CLAIM] ? 64'd0 : next_len_q[ch];
			k[mdre_pkg::CTL_CLAIM] = 1'b0;
			sz = 64'd1 << mdre_pkg::size_log2(cfg);
			if (item.write_data[mdre_pkg::CTL_RUN]) begin
				if (len == 0 || cfg[mdre_pkg::CFG_WR_POS +: 4] !=
				    cfg[mdre_pkg::CFG_RD_POS +: 4] || (len & (sz - 64'd1)) != 0) begin
					k[mdre_pkg::CTL_ERR] = 1'b1;
				end else begin
					k[mdre_pkg::CTL_CLAIM] = 1'b1;
					k[mdre_pkg::CTL_DONE] = 1'b0;
					k[mdre_pkg::CTL_ERR] = 1'b0;
				end
			end
		end else begin
			k[mdre_pkg::CTL_CLAIM] = 1'b0;
			k[mdre_pkg::CTL_RUN] = 1'b0;
			k[mdre_pkg::CTL_DONE] = 1'b1;
		end
		return k;
	endfunction

	// lowest busy channel
	always_comb begin
		tsel = '0;
		tfound = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			if (busy_q[i]) begin
				tsel = mdre_pkg::CH_W'(i);
				tfound = 1'b1;
			end
		end
		tlg = mdre_pkg::size_log2(exec_cfg_q[tsel]);
		tsz = 64'd1 << tlg;
	end

	always_comb begin
		rd = '0;
		case (item.reg_offset)
			mdre_pkg::OFF_CONTROL:   rd = {32'd0, control_q[c]};
			mdre_pkg::OFF_NEXT_CFG:  rd = {32'd0, next_cfg_q[c]};
			mdre_pkg::OFF_NEXT_LEN:  rd = next_len_q[c];
			mdre_pkg::OFF_NEXT_DEST: rd = next_dest_q[c];
			mdre_pkg::OFF_NEXT_SRC:  rd = next_src_q[c];
			mdre_pkg::OFF_EXEC_CFG:  rd = {32'd0, exec_cfg_q[c]};
			mdre_pkg::OFF_EXEC_LEN:  rd = exec_len_q[c];
			mdre_pkg::OFF_EXEC_DEST: rd = exec_dest_q[c];
			mdre_pkg::OFF_EXEC_SRC:  rd = exec_src_q[c];
			default:                 rd = '0;
		endcase
	end

	// control register image after this item, for irq
	always_comb begin
		logic [31:0] k;
		for (int i = 0; i < N; i++) begin
			k = control_q[i];
			if (cmd.do_step && item.action == mdre_pkg::ACT_WRITE && ch_ok &&
			    item.reg_offset == mdre_pkg::OFF_CONTROL && 32'(c) == i) begin
				k = irq_ctl(c);
			end else if (cmd.do_step && item.action == mdre_pkg::ACT_TICK && tfound &&
			             32'(tsel) == i && exec_len_q[i] <= tsz) begin
				k = irq_ctl(tsel);
			end
			irq_nxt[i] = (k[mdre_pkg::CTL_DONE_IE] & k[mdre_pkg::CTL_DONE]) |
			             (k[mdre_pkg::CTL_ERR_IE] & k[mdre_pkg::CTL_ERR]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				control_q[i] <= '0;
				next_cfg_q[i] <= '0;
				next_len_q[i] <= '0;
				next_dest_q[i] <= '0;
				next_src_q[i] <= '0;
				exec_cfg_q[i] <= '0;
				exec_len_q[i] <= '0;
				exec_dest_q[i] <= '0;
				exec_src_q[i] <= '0;
			end
			busy_q <= '0;
		end else if (cmd.do_step) begin
			if (item.action == mdre_pkg::ACT_WRITE && ch_ok) begin
				case (item.reg_offset)
					mdre_pkg::OFF_CONTROL: begin
						logic [31:0] cfg;
						logic [63:0] len, dst, src, sz;
						logic        run_ok;
						control_q[c] <= irq_ctl(c);
						if (item.write_data[mdre_pkg::CTL_CLAIM]) begin
							next_cfg_q[c] <= '0;
							next_len_q[c] <= '0;
							next_dest_q[c] <= '0;
							next_src_q[c] <= '0;
						end
						cfg = item.write_data[mdre_pkg::CTL_CLAIM] ? 32'd0 : next_cfg_q[c];
						len = item.write_data[mdre_pkg::CTL_CLAIM] ? 64'd0 : next_len_q[c];
						dst = item.write_data[mdre_pkg::CTL_CLAIM] ? 64'd0 : next_dest_q[c];
						src = item.write_data[mdre_pkg::CTL_CLAIM] ? 64'd0 : next_src_q[c];
						sz = 64'd1 << mdre_pkg::size_log2(cfg);
						run_ok = item.write_data[mdre_pkg::CTL_RUN] && len != 0 &&
						    cfg[mdre_pkg::CFG_WR_POS +: 4] == cfg[mdre_pkg::CFG_RD_POS +: 4] &&
						    (len & (sz - 64'd1)) == 0;
						busy_q[c] <= run_ok;
						if (run_ok) begin
							exec_cfg_q[c] <= cfg;
							exec_len_q[c] <= len;
							exec_dest_q[c] <= dst;
							exec_src_q[c] <= src;
						end
					end
					mdre_pkg::OFF_NEXT_CFG:  next_cfg_q[c] <= item.write_data[31:0];
					mdre_pkg::OFF_NEXT_LEN:  next_len_q[c] <= item.write_data;
					mdre_pkg::OFF_NEXT_DEST: next_dest_q[c] <= item.write_data;
					mdre_pkg::OFF_NEXT_SRC:  next_src_q[c] <= item.write_data;
					default: ;
				endcase
			end else if (item.action == mdre_pkg::ACT_TICK && tfound) begin
				if (exec_len_q[tsel] <= tsz) begin
					busy_q[tsel] <= 1'b0;
					control_q[tsel] <= irq_ctl(tsel);
					if (next_cfg_q[tsel][mdre_pkg::CFG_REPEAT]) begin
						exec_len_q[tsel] <= next_len_q[tsel];
						exec_dest_q[tsel] <= next_dest_q[tsel];
						exec_src_q[tsel] <= next_src_q[tsel];
					end else begin
						exec_len_q[tsel] <= '0;
						exec_dest_q[tsel] <= exec_dest_q[tsel] + tsz;
						exec_src_q[tsel] <= exec_src_q[tsel] + tsz;
					end
				end else begin
					exec_len_q[tsel] <= exec_len_q[tsel] - tsz;
					exec_dest_q[tsel] <= exec_dest_q[tsel] + tsz;
					exec_src_q[tsel] <= exec_src_q[tsel] + tsz;
				end
			end
		end
	end

	always_comb begin
		result = '0;
		if (item.action == mdre_pkg::ACT_READ && ch_ok)
			result.read_data = rd;
		if (item.action == mdre_pkg::ACT_TICK && tfound) begin
			result.beat_valid = 1'b1;
			result.beat_src = exec_src_q[tsel];
			result.beat_dst = exec_dest_q[tsel];
			result.beat_bytes = tsz[mdre_pkg::BYTES_W-1:0];
		end
		result.irq = |irq_nxt;
	end

	property p_busy_has_len;
		@(posedge clk) disable iff (!arst_n)
			busy_q[0] |-> exec_len_q[0] != 0;
	endproperty
	a_busy_has_len: assert property (p_busy_has_len) else $error("busy channel with zero length");

	property p_beat_on_tick;
		@(posedge clk) disable iff (!arst_n)
			result.beat_valid |-> item.action == mdre_pkg::ACT_TICK && tfound;
	endproperty
	a_beat_on_tick: assert property (p_beat_on_tick) else $error("beat without tick");

	property p_beat_size;
		@(posedge clk) disable iff (!arst_n)
			result.beat_valid |-> $onehot(result.beat_bytes);
	endproperty
	a_beat_size: assert property (p_beat_size) else $error("beat size not power of two");

endmodule

// ===== design/mdre_ctrl.sv =====
module mdre_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output mdre_pkg::cmd_t cmd
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_FULL  = 1'b1;

	logic state_q;

	// accept when output register is free or being drained this cycle
	assign in_ready = (state_q == ST_EMPTY) || out_ready;
	assign cmd.do_step = in_valid && in_ready;
	assign out_valid = (state_q == ST_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			case (state_q)
				ST_EMPTY: if (cmd.do_step) state_q <= ST_FULL;
				ST_FULL:  if (out_ready && !cmd.do_step) state_q <= ST_EMPTY;
				default:  state_q <= ST_EMPTY;
			endcase
		end
	end

	property p_step_ready;
		@(posedge clk) disable iff (!arst_n)
			cmd.do_step |=> out_valid;
	endproperty
	a_step_ready: assert property (p_step_ready) else $error("accepted beat not presented");

	property p_hold;
		@(posedge clk) disable iff (!arst_n)
			out_valid && !out_ready |=> out_valid;
	endproperty
	a_hold: assert property (p_hold) else $error("result dropped");

	property p_ready;
		@(posedge clk) disable iff (!arst_n)
			!out_valid |-> in_ready;
	endproperty
	a_ready: assert property (p_ready) else $error("stalled while empty");

endmodule

// ===== design/multichannel_dma_register_engine.sv =====
// Multichannel DMA register engine.
// in channel: in_valid/in_ready carry one item (action, channel, reg_offset,
// write_data): register read, register write or tick. Each accepted beat
// produces exactly one result on out_valid/out_ready: read data, an optional
// memory beat (source, destination, size) from the lowest running channel,
// and the interrupt level after the item.
// The result appears in the output register in the cycle after accept.
// Throughput: one item per cycle; the register file and tick engine update
// in the accepting cycle, and the output register is taken over as it drains.
// When the receiver stalls, the result is held and in_ready drops until it is
// taken. Reset clears all channel registers, busy flags and the output
// register; the block takes items right after reset.
module multichannel_dma_register_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mdre_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mdre_pkg::out_item_t out_data
);

	mdre_pkg::cmd_t      cmd;
	mdre_pkg::out_item_t res;
	mdre_pkg::out_item_t out_q;

	mdre_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	mdre_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .item(in_data), .result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_q <= '0;
		else if (cmd.do_step)
			out_q <= res;
	end

	assign out_data = out_q;

endmodule
